// File: rtl/psd_pkg.sv
// Package with widths, types and constants shared by the point to segment distance block.
`default_nettype none
package psd_pkg;

  localparam int CW   = 16;           // coordinate width
  localparam int FB   = 16;           // fraction bits of the projection parameter
  localparam int DW   = CW + 1;       // coordinate difference width
  localparam int PW   = 2 * DW;       // product of two differences
  localparam int DOTW = PW + 1;       // dot product width, signed
  localparam int LENW = PW;           // squared length width, unsigned
  localparam int REMW = LENW + 1;     // divider remainder width
  localparam int QW   = FB + 1;       // projection parameter width, below 2.0
  localparam int MW   = DW + QW + 1;  // difference times parameter
  localparam int NW   = PW;           // squared distance width
  localparam int DIV_STAGES  = QW;
  localparam int SQRT_STAGES = DW;
  localparam int LATENCY = 3 + DIV_STAGES + 4 + SQRT_STAGES + 1;

  typedef enum logic [1:0] {
    ST_ON    = 2'd0,
    ST_OUT   = 2'd1,
    ST_DEGEN = 2'd2
  } status_t;

  typedef struct packed {
    status_t              status;
    logic signed [CW-1:0] qx;
    logic signed [CW-1:0] qy;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
  } geo_t;

  typedef struct packed {
    status_t              status;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/psd_front.sv
// Front end: coordinate differences, products, dot product, squared length and classification.
`default_nettype none
module psd_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic signed [psd_pkg::CW-1:0] qx,
  input  wire logic signed [psd_pkg::CW-1:0] qy,
  input  wire logic signed [psd_pkg::CW-1:0] sx,
  input  wire logic signed [psd_pkg::CW-1:0] sy,
  input  wire logic signed [psd_pkg::CW-1:0] ex,
  input  wire logic signed [psd_pkg::CW-1:0] ey,
  output logic                              out_valid,
  output psd_pkg::geo_t                     out_geo,
  output logic [psd_pkg::REMW-1:0]          out_rem,
  output logic [psd_pkg::LENW-1:0]          out_den
);
  import psd_pkg::*;

  logic                 v1_r, v2_r, v3_r;
  geo_t                 g1_r, g2_r, g3_r, g1_nxt, g3_nxt;
  logic signed [DW-1:0] wx_r, wy_r;
  logic signed [PW-1:0] pdx_r, pdy_r, plx_r, ply_r;
  logic signed [DOTW-1:0] dot;
  logic [LENW-1:0]      len2;
  logic [REMW-1:0]      rem_r;
  logic [LENW-1:0]      den_r;
  status_t              st;

  always_comb begin
    g1_nxt        = '0;
    g1_nxt.status = ST_ON;
    g1_nxt.qx     = qx;
    g1_nxt.qy     = qy;
    g1_nxt.sx     = sx;
    g1_nxt.sy     = sy;
    g1_nxt.ax     = DW'(ex) - DW'(sx);
    g1_nxt.ay     = DW'(ey) - DW'(sy);
  end

  assign dot  = DOTW'(pdx_r) + DOTW'(pdy_r);
  assign len2 = LENW'(plx_r) + LENW'(ply_r);

  always_comb begin
    if (len2 == '0) begin
      st = ST_DEGEN;
    end else if (dot[DOTW-1]) begin
      st = ST_OUT;
    end else if ({1'b0, dot[DOTW-2:0]} >= {len2, 1'b0}) begin
      st = ST_OUT;
    end else begin
      st = ST_ON;
    end
  end

  always_comb begin
    g3_nxt        = g2_r;
    g3_nxt.status = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    g1_r  <= g1_nxt;
    wx_r  <= DW'(qx) - DW'(sx);
    wy_r  <= DW'(qy) - DW'(sy);
    g2_r  <= g1_r;
    pdx_r <= wx_r * g1_r.ax;
    pdy_r <= wy_r * g1_r.ay;
    plx_r <= g1_r.ax * g1_r.ax;
    ply_r <= g1_r.ay * g1_r.ay;
    g3_r  <= g3_nxt;
    rem_r <= dot[REMW-1:0];
    den_r <= len2;
  end

  assign out_valid = v3_r;
  assign out_geo   = g3_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
endmodule
`default_nettype wire

// File: rtl/psd_div_step.sv
// One restoring division step that produces one bit of the projection parameter.
`default_nettype none
module psd_div_step (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire psd_pkg::geo_t               in_geo,
  input  wire logic [psd_pkg::REMW-1:0]    in_rem,
  input  wire logic [psd_pkg::LENW-1:0]    in_den,
  input  wire logic [psd_pkg::QW-1:0]      in_quo,
  output logic                             out_valid,
  output psd_pkg::geo_t                    out_geo,
  output logic [psd_pkg::REMW-1:0]         out_rem,
  output logic [psd_pkg::LENW-1:0]         out_den,
  output logic [psd_pkg::QW-1:0]           out_quo
);
  import psd_pkg::*;

  logic            ge;
  logic [REMW-1:0] r_nxt;
  logic            v_r;
  geo_t            g_r;
  logic [REMW-1:0] rem_r;
  logic [LENW-1:0] den_r;
  logic [QW-1:0]   quo_r;

  assign ge    = in_rem >= {1'b0, in_den};
  assign r_nxt = ge ? (in_rem - {1'b0, in_den}) : in_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    g_r   <= in_geo;
    rem_r <= {r_nxt[REMW-2:0], 1'b0};
    den_r <= in_den;
    quo_r <= {in_quo[QW-2:0], ge};
  end

  assign out_valid = v_r;
  assign out_geo   = g_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_quo   = quo_r;
endmodule
`default_nettype wire

// File: rtl/psd_closest.sv
// Range check, closest point on the segment and squared distance to the query point.
`default_nettype none
module psd_closest (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire psd_pkg::geo_t            in_geo,
  input  wire logic [psd_pkg::QW-1:0]   in_quo,
  output logic                          out_valid,
  output psd_pkg::res_t                 out_res,
  output logic [psd_pkg::NW-1:0]        out_n
);
  import psd_pkg::*;

  logic                 v1_r, v2_r, v3_r, v4_r;
  geo_t                 g1_r, g1_nxt;
  logic signed [MW-1:0] mx_r, my_r, sumx, sumy;
  res_t                 r2_r, r3_r, r4_r, r2_nxt;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [PW-1:0] sqx_r, sqy_r;
  logic [NW-1:0]        n_r;
  status_t              st1;

  assign st1  = (in_geo.status == ST_ON && in_quo > QW'(1 << FB)) ? ST_OUT : in_geo.status;
  assign sumx = MW'(g1_r.sx) + (mx_r >>> FB);
  assign sumy = MW'(g1_r.sy) + (my_r >>> FB);

  always_comb begin
    g1_nxt        = in_geo;
    g1_nxt.status = st1;
  end

  always_comb begin
    r2_nxt.status = g1_r.status;
    r2_nxt.cx     = sumx[CW-1:0];
    r2_nxt.cy     = sumy[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    g1_r        <= g1_nxt;
    mx_r        <= in_geo.ax * $signed({1'b0, in_quo});
    my_r        <= in_geo.ay * $signed({1'b0, in_quo});
    r2_r        <= r2_nxt;
    dx_r        <= DW'(g1_r.qx) - DW'(r2_nxt.cx);
    dy_r        <= DW'(g1_r.qy) - DW'(r2_nxt.cy);
    r3_r        <= r2_r;
    sqx_r       <= dx_r * dx_r;
    sqy_r       <= dy_r * dy_r;
    r4_r        <= r3_r;
    n_r         <= NW'(sqx_r) + NW'(sqy_r);
  end

  assign out_valid = v4_r;
  assign out_res   = r4_r;
  assign out_n     = n_r;
endmodule
`default_nettype wire

// File: rtl/psd_sqrt_step.sv
// One digit step of the integer square root of the squared distance.
`default_nettype none
module psd_sqrt_step (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire psd_pkg::res_t          in_res,
  input  wire logic [psd_pkg::NW-1:0] in_n,
  input  wire logic [psd_pkg::NW-1:0] in_root,
  input  wire logic [psd_pkg::NW-1:0] step_bit,
  output logic                        out_valid,
  output psd_pkg::res_t               out_res,
  output logic [psd_pkg::NW-1:0]      out_n,
  output logic [psd_pkg::NW-1:0]      out_root
);
  import psd_pkg::*;

  logic [NW:0]   trial;
  logic          ge;
  logic          v_r;
  res_t          res_r;
  logic [NW-1:0] n_r, root_r;

  assign trial = {1'b0, in_root} + {1'b0, step_bit};
  assign ge    = {1'b0, in_n} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= in_res;
    n_r    <= ge ? (in_n - trial[NW-1:0]) : in_n;
    root_r <= ge ? ((in_root >> 1) + step_bit) : (in_root >> 1);
  end

  assign out_valid = v_r;
  assign out_res   = res_r;
  assign out_n     = n_r;
  assign out_root  = root_r;
endmodule
`default_nettype wire

// File: rtl/point_segment_distance.sv
// Top level of the point to line segment distance pipeline.
// A request is taken at every rising clock edge where start is high and busy
// is low. Busy is never raised: the pipeline accepts a new request in every
// cycle, so the sustained rate is one request per clock.
// Each request carries a query point and the two endpoints of a segment.
// The pipeline forms the dot product and squared length (three stages),
// divides them bit by bit into the projection parameter (one stage per
// quotient bit, seventeen stages), builds the closest point and squared
// distance (four stages), takes the integer square root one digit per stage
// (seventeen stages) and registers the result.
// The result is shown for exactly one cycle with out_valid high. The receiver
// cannot hold it off, and since every request passes through the same
// stages, results come out in request order with no queue needed.
// Status 2 marks a zero-length segment, status 1 a projection that falls
// before the start or past the end; in both cases the point and distance
// read as zero.
// Synchronous reset clears every valid bit, dropping requests in flight;
// the data registers are not reset.
`default_nettype none
module point_segment_distance (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [psd_pkg::CW-1:0] in_query_x,
  input  wire logic signed [psd_pkg::CW-1:0] in_query_y,
  input  wire logic signed [psd_pkg::CW-1:0] in_start_x,
  input  wire logic signed [psd_pkg::CW-1:0] in_start_y,
  input  wire logic signed [psd_pkg::CW-1:0] in_end_x,
  input  wire logic signed [psd_pkg::CW-1:0] in_end_y,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic signed [psd_pkg::CW-1:0]      out_closest_x,
  output logic signed [psd_pkg::CW-1:0]      out_closest_y,
  output logic [psd_pkg::DW-1:0]             out_distance
);
  import psd_pkg::*;

  // Divider chain: index 0 is the front end output.
  logic            dv   [DIV_STAGES+1];
  geo_t            dgeo [DIV_STAGES+1];
  logic [REMW-1:0] drem [DIV_STAGES+1];
  logic [LENW-1:0] dden [DIV_STAGES+1];
  logic [QW-1:0]   dquo [DIV_STAGES+1];

  // Square root chain: index 0 is the closest-point output.
  logic          sv    [SQRT_STAGES+1];
  res_t          sres  [SQRT_STAGES+1];
  logic [NW-1:0] sn    [SQRT_STAGES+1];
  logic [NW-1:0] sroot [SQRT_STAGES+1];

  logic                 ov_r;
  status_t              ost_r;
  logic signed [CW-1:0] ocx_r, ocy_r;
  logic [DW-1:0]        odist_r;
  logic                 on_seg;

  assign busy = 1'b0;

  psd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .qx        (in_query_x),
    .qy        (in_query_y),
    .sx        (in_start_x),
    .sy        (in_start_y),
    .ex        (in_end_x),
    .ey        (in_end_y),
    .out_valid (dv[0]),
    .out_geo   (dgeo[0]),
    .out_rem   (drem[0]),
    .out_den   (dden[0])
  );

  assign dquo[0] = '0;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    psd_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv[i]),
      .in_geo    (dgeo[i]),
      .in_rem    (drem[i]),
      .in_den    (dden[i]),
      .in_quo    (dquo[i]),
      .out_valid (dv[i+1]),
      .out_geo   (dgeo[i+1]),
      .out_rem   (drem[i+1]),
      .out_den   (dden[i+1]),
      .out_quo   (dquo[i+1])
    );
  end

  psd_closest u_closest (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv[DIV_STAGES]),
    .in_geo    (dgeo[DIV_STAGES]),
    .in_quo    (dquo[DIV_STAGES]),
    .out_valid (sv[0]),
    .out_res   (sres[0]),
    .out_n     (sn[0])
  );

  assign sroot[0] = '0;

  // Stage i tests the root digit whose weight is two to the power
  // SQRT_STAGES-1-i; its trial bit is four to that power.
  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
    psd_sqrt_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sv[i]),
      .in_res    (sres[i]),
      .in_n      (sn[i]),
      .in_root   (sroot[i]),
      .step_bit  (NW'(1) << (2 * (SQRT_STAGES - 1 - i))),
      .out_valid (sv[i+1]),
      .out_res   (sres[i+1]),
      .out_n     (sn[i+1]),
      .out_root  (sroot[i+1])
    );
  end

  // Point and distance are forced to zero unless the projection is on the segment.
  assign on_seg = sres[SQRT_STAGES].status == ST_ON;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= sv[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    ost_r   <= sres[SQRT_STAGES].status;
    ocx_r   <= on_seg ? sres[SQRT_STAGES].cx : '0;
    ocy_r   <= on_seg ? sres[SQRT_STAGES].cy : '0;
    odist_r <= on_seg ? sroot[SQRT_STAGES][DW-1:0] : '0;
  end

  assign out_valid     = ov_r;
  assign out_status    = ost_r;
  assign out_closest_x = ocx_r;
  assign out_closest_y = ocy_r;
  assign out_distance  = odist_r;
endmodule
`default_nettype wire

// File: rtl/psd_checker.sv
// Port-level checks for the point to segment distance block and their binding.
`default_nettype none
module psd_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic signed [psd_pkg::CW-1:0] in_start_x,
  input wire logic signed [psd_pkg::CW-1:0] in_start_y,
  input wire logic signed [psd_pkg::CW-1:0] in_end_x,
  input wire logic signed [psd_pkg::CW-1:0] in_end_y,
  input wire logic                          out_valid,
  input wire logic [1:0]                    out_status,
  input wire logic signed [psd_pkg::CW-1:0] out_closest_x,
  input wire logic signed [psd_pkg::CW-1:0] out_closest_y,
  input wire logic [psd_pkg::DW-1:0]        out_distance
);
  import psd_pkg::*;

  // Every result belongs to a request taken exactly one latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  // A zero-length segment always reports the degenerate status.
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_start_x == in_end_x && in_start_y == in_end_y, LATENCY))
    |-> out_status == ST_DEGEN)
    else $error("zero-length segment not flagged");

  // Results off the segment carry no point and no distance.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_ON)
    |-> (out_closest_x == '0 && out_closest_y == '0 && out_distance == '0))
    else $error("non-zero fields with an off-segment status");

  // Status never takes the unused code.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_ON || out_status == ST_OUT || out_status == ST_DEGEN))
    else $error("unused status code");
endmodule

bind point_segment_distance psd_checker u_psd_checker (.*);
`default_nettype wire
